// ===== rtl/mppt_po_pkg.sv =====
// ----------------------------------------------------------------------------
// mppt_po_pkg
// Shared widths, constants and codes of the perturb-and-observe tracker.
// ----------------------------------------------------------------------------
package mppt_po_pkg;

  localparam int unsigned ADC_BITS    = 10;
  localparam int unsigned PWR_W       = 2 * ADC_BITS;
  localparam int unsigned DUTY_W      = 8;
  localparam int unsigned WAIT_W      = 16;
  localparam int unsigned STREAK_W    = 8;
  localparam int unsigned STREAK_MAX  = 255;
  localparam int unsigned STREAK_FAST = 3;
  localparam int unsigned OVR_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  // shared adder: one bit above the power word carries sign / borrow
  localparam int unsigned ALU_W       = PWR_W + 1;
  localparam int unsigned CNT_W       = $clog2(WAIT_W);

  localparam logic [DUTY_W-1:0] DUTY_FORCED_HIGH = '1;

  typedef enum logic [OVR_W-1:0] {
    OVR_NONE = 2'd0,
    OVR_LOW  = 2'd1,
    OVR_HIGH = 2'd2
  } ovr_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_MAX  = 2'd0,
    CFG_DUTY_MIN  = 2'd1,
    CFG_DUTY_STEP = 2'd2,
    CFG_BASE_WAIT = 2'd3
  } cfg_idx_e;

endpackage

// ===== rtl/mppt_po_if.sv =====
// ----------------------------------------------------------------------------
// mppt_po_if
// Valid/ready channels: observation beats in, duty/wait beats out.
// ----------------------------------------------------------------------------
interface mppt_po_in_if;
  logic                            valid;
  logic                            ready;
  logic [mppt_po_pkg::ADC_BITS-1:0] panel_voltage;
  logic [mppt_po_pkg::ADC_BITS-1:0] panel_current;
  logic [mppt_po_pkg::OVR_W-1:0]    override;

  modport source (output valid, panel_voltage, panel_current, override, input ready);
  modport sink   (input valid, panel_voltage, panel_current, override, output ready);
endinterface

interface mppt_po_out_if;
  logic                             valid;
  logic                             ready;
  logic [mppt_po_pkg::DUTY_W-1:0]   duty_out;
  logic [mppt_po_pkg::WAIT_W-1:0]   wait_ms;
  logic                             was_success;

  modport source (output valid, duty_out, wait_ms, was_success, input ready);
  modport sink   (input valid, duty_out, wait_ms, was_success, output ready);
endinterface

// ===== rtl/mppt_perturb_observe_unit.sv =====
// ----------------------------------------------------------------------------
// mppt_perturb_observe_unit
// Perturb-and-observe MPPT step: power, direction, streak-scaled duty move,
// clamp, and streak-shortened wait; multiplies, duty add and divide share one adder.
// ----------------------------------------------------------------------------
// Sequence: power multiply, compare, step multiply, duty add, clamp, then the
//   divide when the updated streak exceeds 3, then the output hand-off.
// One observation beat at a time (input ready only in idle); the 21-bit shared
//   adder is reused by two 10-step shift-add multiplies and a 16-step restoring divide.
// The input side reopens while a finished result still waits on the output.
// Reset (rst_ni, async low): registers to defaults, duty 0, previous power 0,
//   direction down, streak 1; no result pending.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mppt_po_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mppt_po_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  mppt_po_in_if.sink                          in_i,
  mppt_po_out_if.source                       out_o
);
  import mppt_po_pkg::*;

  // Sequencer: each state owns the shared adder for its cycles.
  typedef enum logic [2:0] {
    S_IDLE,    // waiting for an observation beat
    S_MUL_P,   // power = voltage * current, one multiplier bit per cycle
    S_CMP,     // success test, override, direction flip
    S_MUL_S,   // step = duty_step * streak, same shift-add loop
    S_ADD,     // duty +/- step, signed
    S_CLAMP,   // clamp, streak update, divide setup
    S_DIV,     // wait = base_wait / streak, one quotient bit per cycle
    S_FINISH   // hand result to output register
  } state_e;

  state_e               state_q;

  // configuration
  logic [DUTY_W-1:0]    duty_max_q, duty_min_q, duty_step_q;
  logic [WAIT_W-1:0]    base_wait_q;

  // tracker state
  logic [DUTY_W-1:0]    duty_q;
  logic [PWR_W-1:0]     prev_power_q;
  logic                 going_up_q;
  logic [STREAK_W-1:0]  streak_q;

  // datapath
  logic [PWR_W-1:0]     acc_q;      // multiply accumulator
  logic [PWR_W-1:0]     mcand_q;    // shifted multiplicand
  logic [ADC_BITS-1:0]  mplier_q;   // multiplier, consumed LSB first
  logic [ALU_W-1:0]     sum_q;      // signed duty +/- step
  logic [STREAK_W-1:0]  rem_q;      // divider remainder
  logic [WAIT_W-1:0]    quo_q;      // dividend in, quotient out
  logic [CNT_W-1:0]     cnt_q;
  logic [OVR_W-1:0]     ovr_q;
  logic                 success_q;

  // output register
  logic                 out_valid_q;
  logic [DUTY_W-1:0]    duty_out_q;
  logic [WAIT_W-1:0]    wait_out_q;
  logic                 succ_out_q;

  // shared adder
  logic [ALU_W-1:0]     alu_a, alu_b, alu_sum;
  logic                 alu_cin;
  logic [STREAK_W:0]    div_trial;
  logic                 div_neg;
  logic [STREAK_W-1:0]  streak_next;
  logic                 in_fire;
  logic                 out_load;   // result moves into the output register

  assign in_fire   = in_i.valid && in_i.ready;
  assign div_trial = {rem_q, quo_q[WAIT_W-1]};
  assign out_load  = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state_q)
      S_MUL_P, S_MUL_S: begin
        alu_a = ALU_W'(acc_q);
        alu_b = ALU_W'(mcand_q);
      end
      S_ADD: begin
        // step fits in 16 bits (8 x 8); subtract by two's complement
        alu_a   = ALU_W'(duty_q);
        alu_b   = going_up_q ? ALU_W'(acc_q[2*STREAK_W-1:0])
                             : ~ALU_W'(acc_q[2*STREAK_W-1:0]);
        alu_cin = ~going_up_q;
      end
      S_DIV: begin
        alu_a   = ALU_W'(div_trial);
        alu_b   = ~ALU_W'(streak_q);
        alu_cin = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b + ALU_W'(alu_cin);
  assign div_neg = alu_sum[ALU_W-1];   // trial < streak

  // streak after this observation
  always_comb begin
    if (!success_q) begin
      streak_next = STREAK_W'(1);
    end else if (streak_q < STREAK_W'(STREAK_MAX)) begin
      streak_next = streak_q + STREAK_W'(1);
    end else begin
      streak_next = streak_q;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_max_q  <= DUTY_W'(255);
      duty_min_q  <= '0;
      duty_step_q <= DUTY_W'(1);
      base_wait_q <= WAIT_W'(450);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DUTY_MAX:  duty_max_q  <= cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_MIN:  duty_min_q  <= cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_STEP: duty_step_q <= cfg_data_i[DUTY_W-1:0];
        CFG_BASE_WAIT: base_wait_q <= cfg_data_i[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      duty_q       <= '0;
      prev_power_q <= '0;
      going_up_q   <= 1'b0;
      streak_q     <= STREAK_W'(1);
      acc_q        <= '0;
      mcand_q      <= '0;
      mplier_q     <= '0;
      sum_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      cnt_q        <= '0;
      ovr_q        <= '0;
      success_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      duty_out_q   <= '0;
      wait_out_q   <= '0;
      succ_out_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            acc_q    <= '0;
            mcand_q  <= PWR_W'(in_i.panel_current[ADC_BITS-1:0]);
            mplier_q <= in_i.panel_voltage[ADC_BITS-1:0];
            ovr_q    <= in_i.override;
            cnt_q    <= '0;
            state_q  <= S_MUL_P;
          end
        end

        S_MUL_P, S_MUL_S: begin
          if (mplier_q[0]) begin
            acc_q <= alu_sum[PWR_W-1:0];
          end
          mcand_q  <= {mcand_q[PWR_W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[ADC_BITS-1:1]};
          cnt_q    <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(ADC_BITS - 1)) begin
            state_q <= (state_q == S_MUL_P) ? S_CMP : S_ADD;
          end
        end

        S_CMP: begin
          success_q    <= (acc_q > prev_power_q);
          prev_power_q <= acc_q;
          going_up_q   <= going_up_q ^ ~(acc_q > prev_power_q);
          case (ovr_q)
            OVR_LOW:  duty_q <= '0;
            OVR_HIGH: duty_q <= DUTY_FORCED_HIGH;
            default:  ;   // normal, and the unused code
          endcase
          // step uses the streak before its update
          acc_q    <= '0;
          mcand_q  <= PWR_W'(duty_step_q);
          mplier_q <= ADC_BITS'(streak_q);
          cnt_q    <= '0;
          state_q  <= S_MUL_S;
        end

        S_ADD: begin
          sum_q   <= alu_sum;
          state_q <= S_CLAMP;
        end

        S_CLAMP: begin
          // max test first: with min > max the first hit wins
          if ($signed(sum_q) >= $signed(ALU_W'(duty_max_q))) begin
            duty_q <= duty_max_q;
          end else if ($signed(sum_q) <= $signed(ALU_W'(duty_min_q))) begin
            duty_q <= duty_min_q;
          end else begin
            duty_q <= sum_q[DUTY_W-1:0];
          end
          streak_q <= streak_next;
          quo_q    <= base_wait_q;
          rem_q    <= '0;
          cnt_q    <= '0;
          state_q  <= (streak_next > STREAK_W'(STREAK_FAST)) ? S_DIV : S_FINISH;
        end

        S_DIV: begin
          rem_q   <= div_neg ? div_trial[STREAK_W-1:0] : alu_sum[STREAK_W-1:0];
          quo_q   <= {quo_q[WAIT_W-2:0], ~div_neg};
          cnt_q   <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(WAIT_W - 1)) begin
            state_q <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_load) begin
            duty_out_q  <= duty_q;
            wait_out_q  <= quo_q;
            succ_out_q  <= success_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.duty_out    = duty_out_q;
  assign out_o.wait_ms     = wait_out_q;
  assign out_o.was_success = succ_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_MUL_P))
    else $error("accepted beat did not start the power multiply");

  a_streak_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    streak_q != '0)
    else $error("streak reached zero");

  a_wait_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (wait_out_q <= base_wait_q))
    else $error("wait exceeds base wait");

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (duty_min_q <= duty_max_q)) |->
      ((duty_out_q >= duty_min_q) && (duty_out_q <= duty_max_q)))
    else $error("duty outside clamp window");

  a_div_short_streak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (streak_q > STREAK_W'(STREAK_FAST)))
    else $error("divide running with a short streak");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the perturb-and-observe MPPT step. A scoreboard
// class tracks its own copy of the registers and tracker state, predicts one
// result beat per accepted observation and checks results in order. Stimulus
// is a short directed part, then rising-power runs with random content, mixed
// with noise, over several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mppt_po_pkg::*;

  // override code with no name in the package: acts as normal
  localparam logic [OVR_W-1:0] OVR_SPARE = 2'd3;
  localparam int unsigned ADC_TOP = (1 << ADC_BITS) - 1;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_out;
    logic [WAIT_W-1:0] wait_ms;
    logic              was_success;
  } mppt_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracker state, duty/wait prediction, in-order result check
  // --------------------------------------------------------------------------
  class mppt_tracker;
    logic [DUTY_W-1:0]   duty_max;
    logic [DUTY_W-1:0]   duty_min;
    logic [DUTY_W-1:0]   duty_step;
    logic [WAIT_W-1:0]   base_wait;
    logic [DUTY_W-1:0]   duty;
    logic [PWR_W-1:0]    prior_pwr;
    bit                  going_up;
    logic [STREAK_W-1:0] streak;
    mppt_result_t        result_q[$];
    int                  errors;
    int                  checked;
    int                  top_streak;

    function new();
      duty_max   = '1;
      duty_min   = '0;
      duty_step  = 8'd1;
      base_wait  = 16'd450;
      duty       = '0;
      prior_pwr  = '0;
      going_up   = 1'b0;
      streak     = 8'd1;
      errors     = 0;
      checked    = 0;
      top_streak = 1;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DUTY_MAX:  duty_max  = data[DUTY_W-1:0];
        CFG_DUTY_MIN:  duty_min  = data[DUTY_W-1:0];
        CFG_DUTY_STEP: duty_step = data[DUTY_W-1:0];
        CFG_BASE_WAIT: base_wait = data[WAIT_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted observation beat -> one expected result beat
    function void note_obs(logic [ADC_BITS-1:0] v, logic [ADC_BITS-1:0] c,
                           logic [OVR_W-1:0] ovr);
      logic [PWR_W-1:0] power;
      bit               success;
      int               step;
      int               sum;
      mppt_result_t     res;
      power      = PWR_W'(v) * PWR_W'(c);
      success    = (power > prior_pwr);
      prior_pwr  = power;
      if (ovr == OVR_LOW) begin
        duty = '0;
      end else if (ovr == OVR_HIGH) begin
        duty = DUTY_FORCED_HIGH;
      end
      step = int'(duty_step) * int'(streak);
      if (!success) going_up = !going_up;
      sum = going_up ? int'(duty) + step : int'(duty) - step;
      // max test first, so an inverted window resolves to duty_max when it can
      if (sum >= int'(duty_max)) begin
        duty = duty_max;
      end else if (sum <= int'(duty_min)) begin
        duty = duty_min;
      end else begin
        duty = sum[DUTY_W-1:0];
      end
      if (success) begin
        if (streak < STREAK_MAX) streak = streak + 1'b1;
      end else begin
        streak = 8'd1;
      end
      if (int'(streak) > top_streak) top_streak = int'(streak);
      res.duty_out    = duty;
      res.wait_ms     = (streak > STREAK_FAST) ? base_wait / streak : base_wait;
      res.was_success = success;
      result_q.push_back(res);
    endfunction

    function void check_result(mppt_result_t got);
      mppt_result_t exp_res;
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected: duty_out=%0d wait_ms=%0d",
               got.duty_out, got.wait_ms);
        errors++;
        return;
      end
      exp_res = result_q.pop_front();
      checked++;
      if (got.duty_out !== exp_res.duty_out) begin
        $error("duty_out: expected %0d, got %0d", exp_res.duty_out, got.duty_out);
        errors++;
      end
      if (got.wait_ms !== exp_res.wait_ms) begin
        $error("wait_ms: expected %0d, got %0d", exp_res.wait_ms, got.wait_ms);
        errors++;
      end
      if (got.was_success !== exp_res.was_success) begin
        $error("was_success: expected %0d, got %0d", exp_res.was_success,
               got.was_success);
        errors++;
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  always #2 clk_i = ~clk_i;

  mppt_po_in_if  obs_if ();
  mppt_po_out_if res_if ();

  mppt_perturb_observe_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (obs_if),
    .out_o      (res_if)
  );

  mppt_tracker tracker = new();

  int send_idle_pct = 15;  // chance per cycle that the sender holds off
  int recv_idle_pct = 84;  // chance per cycle that ready stays low
  int obs_sent      = 0;
  int settings_used = 1;   // reset defaults count as the first setting
  int gen_power     = 0;   // power of the last observation handed to the DUT

  // Receiver: ready re-rolled every cycle against the current idle rate.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result monitor: values read here are the ones that held before the edge,
  // so a beat is taken exactly when valid and ready were both high.
  always @(posedge clk_i) begin
    mppt_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.duty_out    = res_if.duty_out;
      got.wait_ms     = res_if.wait_ms;
      got.was_success = res_if.was_success;
      tracker.check_result(got);
    end
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks (all called right after a rising edge)
  // --------------------------------------------------------------------------

  // One observation beat. valid stays high into the next beat unless the
  // sender decides to idle first, so it never toggles within a step.
  task automatic send_obs(logic [ADC_BITS-1:0] v, logic [ADC_BITS-1:0] c,
                          logic [OVR_W-1:0] ovr);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      obs_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    obs_if.valid         <= 1'b1;
    obs_if.panel_voltage <= v;
    obs_if.panel_current <= c;
    obs_if.override      <= ovr;
    do @(posedge clk_i); while (!obs_if.ready);
    tracker.note_obs(v, c, ovr);
    gen_power = int'(v) * int'(c);
    obs_sent++;
  endtask

  // Drop valid and hold off until every expected result beat has come.
  task automatic wait_idle();
    obs_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // Register write; the enable is left high for back-to-back writes.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  // Full register set, written only with the block drained. Unused high bits
  // of the 8-bit registers get random junk, which must be ignored.
  task automatic program_regs(logic [DUTY_W-1:0] dmax, logic [DUTY_W-1:0] dmin,
                              logic [DUTY_W-1:0] dstep, logic [WAIT_W-1:0] bwait);
    wait_idle();
    write_reg(CFG_DUTY_MAX,  {8'($urandom_range(0, 255)), dmax});
    write_reg(CFG_DUTY_MIN,  {8'($urandom_range(0, 255)), dmin});
    write_reg(CFG_DUTY_STEP, {8'($urandom_range(0, 255)), dstep});
    write_reg(CFG_BASE_WAIT, bwait);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Run of strictly rising power with random content. A gentle run keeps
  // each rise small so it can last long enough to saturate the streak.
  task automatic rising_run(int len, bit gentle);
    int               v;
    int               c;
    int               cmin;
    int               span;
    logic [OVR_W-1:0] ovr;
    for (int k = 0; k < len; k++) begin
      v    = gentle ? $urandom_range(1, 400) : $urandom_range(1, ADC_TOP);
      cmin = gen_power / v + 1;
      if (cmin > ADC_TOP) begin
        v    = ADC_TOP;
        cmin = gen_power / v + 1;
      end
      if (cmin > ADC_TOP) break;  // power already at its ceiling
      span = ADC_TOP - cmin;
      if (gentle && span > 2) span = 2;
      c   = cmin + $urandom_range(0, span);
      ovr = ($urandom_range(0, 99) < 80) ? OVR_NONE : OVR_W'($urandom_range(0, 3));
      send_obs(v[ADC_BITS-1:0], c[ADC_BITS-1:0], ovr);
    end
  endtask

  // Mostly rising runs; the rest is noise and zero-power beats that restart
  // the power ladder. Now and then the sender waits for the block to drain.
  task automatic random_segment(int count);
    int start;
    int roll;
    int len;
    start = obs_sent;
    while (obs_sent - start < count) begin
      if ($urandom_range(0, 99) < 3) wait_idle();
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        len = $urandom_range(2, 12);
        if (len > count - (obs_sent - start)) len = count - (obs_sent - start);
        rising_run(len, 1'b0);
      end else if (roll < 90) begin
        send_obs(ADC_BITS'($urandom_range(0, ADC_TOP)),
                 ADC_BITS'($urandom_range(0, ADC_TOP)),
                 OVR_W'($urandom_range(0, 3)));
      end else begin
        send_obs('0, ADC_BITS'($urandom_range(0, ADC_TOP)),
                 OVR_W'($urandom_range(0, 3)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_DUTY_MAX;
    cfg_data_i           <= '0;
    obs_if.valid         <= 1'b0;
    obs_if.panel_voltage <= '0;
    obs_if.panel_current <= '0;
    obs_if.override      <= OVR_NONE;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset register values.
    // First beat: zero power against the zero reset power is not a success.
    send_obs(10'd0, 10'd0, OVR_NONE);
    send_obs(10'd1023, 10'd1023, OVR_NONE);  // full-scale power, success
    send_obs(10'd1023, 10'd1023, OVR_NONE);  // equal power is a failure
    send_obs(10'd0, 10'd1023, OVR_LOW);      // forced low, then perturbed
    send_obs(10'd1023, 10'd0, OVR_HIGH);     // forced high, equal zero power
    send_obs(10'd1, 10'd1, OVR_SPARE);       // spare override code acts normal
    // climb: streak passes 3, so the wait starts shrinking
    for (int k = 2; k <= 12; k++) send_obs(ADC_BITS'(k), 10'd1, OVR_NONE);
    send_obs(10'd5, 10'd5, OVR_HIGH);        // success on top of a forced duty
    send_obs(10'd512, 10'd512, OVR_LOW);
    send_obs(10'd0, 10'd0, OVR_NONE);        // power falls, streak back to 1

    // Sender idles 15 %, receiver 84 %.
    program_regs(8'd255, 8'd0, 8'd1, 16'd450);
    random_segment(30);
    program_regs(8'd200, 8'd30, 8'd3, 16'd1000);
    random_segment(30);

    // Roles swapped: sender idles 84 %, receiver 15 %.
    send_idle_pct = 84;
    recv_idle_pct = 15;
    program_regs(8'd10, 8'd240, 8'd255, 16'hFFFF);  // inverted window, big step
    random_segment(25);
    program_regs(8'd255, 8'd0, 8'd0, 16'd0);        // zero step, zero wait
    random_segment(25);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(8'd0, 8'd255, 8'd2, 16'd3);        // fully inverted window
    random_segment(25);
    // Long gentle climb from zero power drives the streak into saturation.
    program_regs(8'd255, 8'd0, 8'd1, 16'hFFFF);
    send_obs('0, ADC_BITS'($urandom_range(0, ADC_TOP)), OVR_NONE);
    rising_run(270, 1'b1);
    random_segment(20);

    // Drain, then let the pipeline settle for more than one full latency.
    obs_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (64) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $error("%0d expected result beats never arrived", tracker.pending());
      tracker.errors++;
    end

    $display("Run covered %0d observation beats over %0d register settings,",
             obs_sent, settings_used);
    $display("%0d result beats checked; longest success streak %0d.",
             tracker.checked, tracker.top_streak);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mppt_po_pkg.sv
rtl/mppt_po_if.sv
rtl/mppt_perturb_observe_unit.sv
tb/tb_top.sv
